// ===== rtl/veiq_pkg.sv =====
`timescale 1ns / 1ps
// types, codes and delivery packing for the virtual event injection queue
package veiq_pkg;

  typedef enum logic [1:0] {
    KIND_INJECT   = 2'd0,
    KIND_EXT_EXIT = 2'd1,
    KIND_WINDOW   = 2'd2
  } veiq_kind_e;

  typedef enum logic [2:0] {
    ACT_DELIVERED = 3'd0,
    ACT_QUEUED    = 3'd1,
    ACT_NMI       = 3'd2,
    ACT_IGNORED   = 3'd3,
    ACT_DROPPED   = 3'd4,
    ACT_EMPTY     = 3'd5
  } veiq_action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_HOLD
  } veiq_state_e;

  localparam logic [2:0] TYPE_EXT     = 3'd0;
  localparam logic [2:0] TYPE_NMI     = 3'd2;
  localparam logic [2:0] TYPE_HW_EXC  = 3'd3;
  localparam logic [2:0] TYPE_SW_INT  = 3'd4;
  localparam logic [2:0] TYPE_PRIV_SW = 3'd5;
  localparam logic [2:0] TYPE_SW_EXC  = 3'd6;

  localparam logic [7:0] VEC_DF = 8'd8;
  localparam logic [7:0] VEC_TS = 8'd10;
  localparam logic [7:0] VEC_PF = 8'd14;
  localparam logic [7:0] VEC_AC = 8'd17;

  localparam logic [14:0] ERR_MASK = 15'h7FFF;

  typedef struct packed {
    logic [15:0] err;
    logic [3:0]  len;
    logic [2:0]  typ;
    logic [7:0]  vec;
  } veiq_evt_t;

  typedef struct packed {
    veiq_action_e action;
    logic [31:0]  entry_word;
    logic         entry_write;
    logic [14:0]  err_val;
    logic         error_write;
    logic [3:0]   length;
    logic         length_write;
  } veiq_res_t;

  function automatic veiq_res_t no_write(input veiq_action_e act);
    veiq_res_t r;
    r = '0;
    r.action = act;
    return r;
  endfunction

  function automatic veiq_res_t deliver(input veiq_evt_t e);
    veiq_res_t r;
    logic      de;
    r  = '0;
    de = (e.typ == TYPE_HW_EXC) && (e.vec inside {VEC_DF, [VEC_TS:VEC_PF], VEC_AC});
    if (e.typ == TYPE_NMI) begin
      r.action = ACT_NMI;
    end else begin
      r.action      = ACT_DELIVERED;
      r.entry_word  = {1'b1, 19'b0, de, e.typ, e.vec};
      r.entry_write = 1'b1;
      if (de) begin
        r.err_val     = e.err[14:0] & ERR_MASK;
        r.error_write = 1'b1;
      end
      if (e.typ inside {TYPE_SW_INT, TYPE_PRIV_SW, TYPE_SW_EXC}) begin
        r.length       = e.len;
        r.length_write = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/virtual_event_injection_queue.sv =====
`timescale 1ns / 1ps
// virtual event injection queue: deliver-or-defer decision around an event store memory
// result registered in the output register, through the skid hold register if the output
//   stalls; a window-exit pop first reads the event store, and the input stalls meanwhile
// throughput: one item per cycle while the output is not stalled and no window exit pops
// reset clears head, tail, count, window flag and the output valid; the event store is
//   not cleared and only entries written since reset are ever read
module virtual_event_injection_queue #(
  parameter int QUEUE_DEPTH = 16,
  localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      kind_i,
  input  logic [7:0]      vector_i,
  input  logic [2:0]      event_type_i,
  input  logic [3:0]      instr_len_i,
  input  logic [15:0]     error_code_i,
  input  logic            sti_blocking_i,
  input  logic            guest_if_i,
  input  logic [4:0]      interruptibility_i,
  input  logic            entry_busy_i,
  input  logic [1:0]      activity_state_i,
  input  logic            exit_valid_i,
  input  logic            iret_nmi_unblock_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [2:0]      action_o,
  output logic [31:0]     entry_word_o,
  output logic            entry_write_o,
  output logic [14:0]     error_code_out_o,
  output logic            error_write_o,
  output logic [3:0]      length_out_o,
  output logic            length_write_o,
  output logic            window_exiting_o,
  output logic [CntW-1:0] queue_count_o
);

  localparam logic [CntW-1:0] Full    = CntW'(QUEUE_DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(QUEUE_DEPTH - 1);

  veiq_pkg::veiq_state_e state_q, state_d;

  logic [IdxW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            win_q, win_d;

  veiq_pkg::veiq_evt_t event_store_q [QUEUE_DEPTH];
  veiq_pkg::veiq_evt_t rdata_q;
  veiq_pkg::veiq_evt_t in_evt;
  logic                mem_we, mem_re;

  veiq_pkg::veiq_res_t cand, hold_q, out_q;
  logic                cand_valid;
  logic                hold_win_q, out_win_q;
  logic [CntW-1:0]     hold_cnt_q, out_cnt_q;
  logic                out_valid_q, out_free;
  logic                in_acc, is_pop, defer, bad_exit;

  assign in_evt   = '{err: error_code_i, len: instr_len_i, typ: event_type_i, vec: vector_i};
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign bad_exit = !exit_valid_i || iret_nmi_unblock_i;
  assign defer    = sti_blocking_i
                 || (event_type_i == veiq_pkg::TYPE_EXT
                     && (!guest_if_i || interruptibility_i != 5'd0))
                 || cnt_q != '0 || entry_busy_i || activity_state_i != 2'd0;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      veiq_pkg::ST_IDLE: begin
        if (in_acc && is_pop) begin
          state_d = veiq_pkg::ST_READ;
        end else if (in_acc && !out_free) begin
          state_d = veiq_pkg::ST_HOLD;
        end
      end
      veiq_pkg::ST_READ: begin
        state_d = out_free ? veiq_pkg::ST_IDLE : veiq_pkg::ST_HOLD;
      end
      veiq_pkg::ST_HOLD: begin
        if (out_free) begin
          state_d = veiq_pkg::ST_IDLE;
        end
      end
      default: state_d = veiq_pkg::ST_IDLE;
    endcase
  end

  // decision and queue bookkeeping
  always_comb begin
    in_stall_o = (state_q != veiq_pkg::ST_IDLE);
    head_d     = head_q;
    tail_d     = tail_q;
    cnt_d      = cnt_q;
    win_d      = win_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    is_pop     = 1'b0;
    cand       = veiq_pkg::no_write(veiq_pkg::ACT_IGNORED);
    cand_valid = 1'b0;
    case (state_q)
      veiq_pkg::ST_IDLE: begin
        case (kind_i)
          veiq_pkg::KIND_INJECT, veiq_pkg::KIND_EXT_EXIT: begin
            if (kind_i == veiq_pkg::KIND_EXT_EXIT && bad_exit) begin
              cand = veiq_pkg::no_write(veiq_pkg::ACT_IGNORED);
            end else if (defer) begin
              win_d = 1'b1;
              if (cnt_q == Full) begin
                cand = veiq_pkg::no_write(veiq_pkg::ACT_DROPPED);
              end else begin
                cand   = veiq_pkg::no_write(veiq_pkg::ACT_QUEUED);
                mem_we = in_acc;
                tail_d = (tail_q == LastIdx) ? '0 : tail_q + IdxW'(1);
                cnt_d  = cnt_q + CntW'(1);
              end
            end else begin
              cand = veiq_pkg::deliver(in_evt);
            end
          end
          veiq_pkg::KIND_WINDOW: begin
            if (cnt_q == '0) begin
              cand = veiq_pkg::no_write(veiq_pkg::ACT_EMPTY);
            end else begin
              is_pop = 1'b1;
              mem_re = in_acc;
              head_d = (head_q == LastIdx) ? '0 : head_q + IdxW'(1);
              cnt_d  = cnt_q - CntW'(1);
            end
          end
          default: cand = veiq_pkg::no_write(veiq_pkg::ACT_IGNORED);
        endcase
        cand_valid = in_acc && !is_pop;
        if (!in_acc) begin
          head_d = head_q;
          tail_d = tail_q;
          cnt_d  = cnt_q;
          win_d  = win_q;
        end
      end
      veiq_pkg::ST_READ: begin
        cand       = veiq_pkg::deliver(rdata_q);
        cand_valid = 1'b1;
        win_d      = (cnt_q != '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= veiq_pkg::ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      win_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      win_q       <= win_d;
      if (out_free) begin
        out_valid_q <= (state_q == veiq_pkg::ST_HOLD) || cand_valid;
      end
    end
  end

  // event store, one write or one read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      event_store_q[tail_q] <= in_evt;
    end
    if (mem_re) begin
      rdata_q <= event_store_q[head_q];
    end
  end

  // output register and skid holding
  always_ff @(posedge clk_i) begin
    if (cand_valid && !out_free) begin
      hold_q     <= cand;
      hold_win_q <= win_d;
      hold_cnt_q <= cnt_d;
    end
    if (out_free) begin
      if (state_q == veiq_pkg::ST_HOLD) begin
        out_q     <= hold_q;
        out_win_q <= hold_win_q;
        out_cnt_q <= hold_cnt_q;
      end else if (cand_valid) begin
        out_q     <= cand;
        out_win_q <= win_d;
        out_cnt_q <= cnt_d;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign action_o         = out_q.action;
  assign entry_word_o     = out_q.entry_word;
  assign entry_write_o    = out_q.entry_write;
  assign error_code_out_o = out_q.err_val;
  assign error_write_o    = out_q.error_write;
  assign length_out_o     = out_q.length;
  assign length_write_o   = out_q.length_write;
  assign window_exiting_o = out_win_q;
  assign queue_count_o    = out_cnt_q;

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Full)
    else $error("pending count above queue depth");

  a_read_after_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == veiq_pkg::ST_READ |-> $past(in_valid_i && !in_stall_o))
    else $error("store read without a popping beat");

  a_write_delivered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_write_o |-> action_o == veiq_pkg::ACT_DELIVERED)
    else $error("entry word written without delivery");

  a_window_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && queue_count_o != '0 |-> window_exiting_o)
    else $error("window exiting off while events pending");

endmodule
